/* rtl/core/bchc_pkg.sv */
package bchc_pkg;

    localparam int OP_W         = 2;
    localparam int LEVEL_W      = 17;
    localparam int ON_W         = 24;
    localparam int LEN_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int OUT_DATA_W   = 24;

    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHARGE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH   = 2'd3;

    localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST  = 17'd43000;
    localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 17'd53000;
    localparam logic [ON_W-1:0]    MIN_CHARGE_RST     = 24'd30000;
    localparam logic [LEN_W-1:0]   BLOCK_LENGTH_RST   = 8'd100;

    localparam logic [LEVEL_W-1:0] SUM_MAX = {LEVEL_W{1'b1}};
    localparam logic [ON_W-1:0]    ON_MAX  = {ON_W{1'b1}};

    typedef struct packed {
        logic [LEVEL_W-1:0] low_threshold;
        logic [LEVEL_W-1:0] high_threshold;
        logic [ON_W-1:0]    min_charge_ticks;
        logic [LEN_W-1:0]   block_length;
    } bchc_cfg_t;

    // Packed from the top down so that charger_enable lands in bit 0.
    typedef struct packed {
        logic               block_done;
        logic [LEVEL_W-1:0] charge_level;
        logic               charger_enable;
    } bchc_result_t;

    localparam int RESULT_W = $bits(bchc_result_t);

endpackage

/* rtl/core/bchc_step.sv */
module bchc_step #(
    parameter int MAX_BLOCK   = 128,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [bchc_pkg::OP_W-1:0]   opcode,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  bchc_pkg::bchc_cfg_t         cfg,
    output bchc_pkg::bchc_result_t      result
);
    import bchc_pkg::*;

    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
    localparam int LEN_CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [LEVEL_W-1:0]   sum_reg;
    logic [LEVEL_W-1:0]   sum_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic [LEVEL_W-1:0]   level_next;
    logic                 charging_reg;
    logic                 charging_next;
    logic [ON_W-1:0]      on_time_reg;
    logic [ON_W-1:0]      on_time_next;

    logic [LEN_CMP_W-1:0] len_ext;
    logic [LEN_CMP_W-1:0] eff_len;
    logic [CNT_W-1:0]     cnt_inc;
    logic [LEVEL_W:0]     sum_wide;
    logic [LEVEL_W-1:0]   sum_sat;
    logic                 done;

    always_comb
    begin
        len_ext = LEN_CMP_W'(cfg.block_length);
        if (len_ext == '0)
        begin
            eff_len = LEN_CMP_W'(1);
        end
        else if (len_ext > LEN_CMP_W'(MAX_BLOCK))
        begin
            eff_len = LEN_CMP_W'(MAX_BLOCK);
        end
        else
        begin
            eff_len = len_ext;
        end

        cnt_inc  = count_reg + CNT_W'(1);
        sum_wide = {1'b0, sum_reg} + (LEVEL_W + 1)'(sample);
        sum_sat  = sum_wide[LEVEL_W] ? SUM_MAX : sum_wide[LEVEL_W-1:0];

        count_next    = count_reg;
        sum_next      = sum_reg;
        level_next    = level_reg;
        charging_next = charging_reg;
        on_time_next  = on_time_reg;
        done          = 1'b0;

        case (opcode)
            OP_SAMPLE:
            begin
                if (LEN_CMP_W'(cnt_inc) >= eff_len)
                begin
                    done       = 1'b1;
                    level_next = sum_sat;
                    sum_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    sum_next   = sum_sat;
                    count_next = cnt_inc;
                end
            end
            OP_TICK:
            begin
                if (charging_reg && (on_time_reg != ON_MAX))
                begin
                    on_time_next = on_time_reg + ON_W'(1);
                end
            end
            OP_CHECK:
            begin
                if (level_reg < cfg.low_threshold)
                begin
                    if (!charging_reg)
                    begin
                        charging_next = 1'b1;
                        on_time_next  = '0;
                    end
                end
                else if (level_reg > cfg.high_threshold)
                begin
                    if (charging_reg && (on_time_reg > cfg.min_charge_ticks))
                    begin
                        charging_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.charger_enable = charging_next;
        result.charge_level   = level_next;
        result.block_done     = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            level_reg    <= '0;
            charging_reg <= 1'b0;
            on_time_reg  <= '0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            level_reg    <= level_next;
            charging_reg <= charging_next;
            on_time_reg  <= on_time_next;
        end
    end

endmodule

/* rtl/core/battery_charge_hysteresis_control_top.sv */
// Channel   Kind        Contents of one word
// s_axis    stream in   tuser: opcode; tdata: sample
// m_axis    stream out  tdata: charger_enable, charge_level, block_done
// cfg       write only  cfg_index selects the register, cfg_data carries it
//
// One word is accepted per cycle while s_axis_tready is high; its result is offered
// on m_axis once it has been loaded through the input register and then the result
// register around a single update step.
// Reset clears the accumulator, the held level, the charger state and the
// on-time counter, and loads the default thresholds and block length.
// A stalled output keeps one word pending in the input register and then holds
// s_axis_tready low until the result register drains.
module battery_charge_hysteresis_control_top #(
    parameter int MAX_BLOCK   = 128,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Bits from the lowest: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // Bits from the lowest: opcode.
    input  logic [bchc_pkg::OP_W-1:0]            s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Bits from the lowest: charger_enable, charge_level, block_done.
    output logic [bchc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,

    input  logic                                 cfg_we,
    input  logic [bchc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bchc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bchc_pkg::*;

    bchc_cfg_t             cfg_reg;
    logic                  in_valid_reg;
    logic [OP_W-1:0]       op_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                  out_valid_reg;
    bchc_result_t          result_reg;
    bchc_result_t          result_next;
    logic                  advance;
    logic                  in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold    <= LOW_THRESHOLD_RST;
            cfg_reg.high_threshold   <= HIGH_THRESHOLD_RST;
            cfg_reg.min_charge_ticks <= MIN_CHARGE_RST;
            cfg_reg.block_length     <= BLOCK_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW_THRESHOLD:  cfg_reg.low_threshold    <= cfg_data[LEVEL_W-1:0];
                CFG_HIGH_THRESHOLD: cfg_reg.high_threshold   <= cfg_data[LEVEL_W-1:0];
                CFG_MIN_CHARGE:     cfg_reg.min_charge_ticks <= cfg_data[ON_W-1:0];
                CFG_BLOCK_LENGTH:   cfg_reg.block_length     <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= s_axis_tuser;
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    bchc_step #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .opcode  (op_reg),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

endmodule

/* rtl/core/bchc_checker.sv */
module bchc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bchc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import bchc_pkg::*;

    bchc_result_t cur;
    logic         out_take;
    logic         seen_reg;
    logic         enable_reg;
    logic [LEVEL_W-1:0] level_reg;

    assign cur      = m_axis_tdata[RESULT_W-1:0];
    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            enable_reg <= 1'b0;
            level_reg  <= '0;
        end
        else if (out_take)
        begin
            seen_reg   <= 1'b1;
            enable_reg <= cur.charger_enable;
            level_reg  <= cur.charge_level;
        end
    end

    // A word that is held back must not change until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // The input side only stalls behind a full, stalled result register.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // The held level only moves on a word that completes a block.
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg && !cur.block_done |-> cur.charge_level == level_reg)
        else $error("battery level changed without a completed block");

    // The charger only switches on a check, so never on a word that completes a block.
    a_switch_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg && (cur.charger_enable != enable_reg) |-> !cur.block_done)
        else $error("charger switched on a block completion");

    // The first word after reset starts with the level at zero.
    a_first_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !seen_reg && !cur.block_done |-> cur.charge_level == '0)
        else $error("held level not zero after reset");

endmodule

bind battery_charge_hysteresis_control_top bchc_checker u_bchc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bchc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int MAX_BLOCK   = 128;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 100;

    typedef enum {ROW_WORD, ROW_SETUP} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [OP_W-1:0]       op;
        logic [9:0]            smp;
        bit                    typed;
        bchc_result_t          want;
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        logic [CFG_DATA_W-1:0] min_on;
        logic [CFG_DATA_W-1:0] len;
    } plan_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // Shadow copy of the controller's registers and state.
    int unsigned lvl_low    = 32'(LOW_THRESHOLD_RST);
    int unsigned lvl_high   = 32'(HIGH_THRESHOLD_RST);
    int unsigned min_ticks  = 32'(MIN_CHARGE_RST);
    int unsigned blk_len    = 32'(BLOCK_LENGTH_RST);
    int unsigned acc_count  = 0;
    int unsigned acc_sum    = 0;
    int unsigned held_level = 0;
    int unsigned on_time    = 0;
    bit          charging   = 1'b0;

    bchc_result_t status_q[$];
    int           errors       = 0;
    bit           idle_on      = 1'b1;
    logic         stall_toggle = 1'b0;
    logic         stall_seen   = 1'b0;
    int           hold_left    = 0;
    int           quiet        = 0;

    battery_charge_hysteresis_control_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bchc_result_t next_status(input logic [OP_W-1:0] op,
                                                 input logic [9:0] smp);
        bchc_result_t r;
        int unsigned  eff;
        r = '0;
        eff = (blk_len == 0) ? 1 : ((blk_len > MAX_BLOCK) ? MAX_BLOCK : blk_len);
        case (op)
            OP_SAMPLE:
            begin
                acc_sum = acc_sum + 32'(smp);
                if (acc_sum > 32'(SUM_MAX))
                begin
                    acc_sum = 32'(SUM_MAX);
                end
                acc_count++;
                if (acc_count >= eff)
                begin
                    held_level   = acc_sum;
                    acc_sum      = 0;
                    acc_count    = 0;
                    r.block_done = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (charging && on_time < 32'(ON_MAX))
                begin
                    on_time++;
                end
            end
            OP_CHECK:
            begin
                if (held_level < lvl_low)
                begin
                    if (!charging)
                    begin
                        charging = 1'b1;
                        on_time  = 0;
                    end
                end
                else if (held_level > lvl_high)
                begin
                    if (charging && on_time > min_ticks)
                    begin
                        charging = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.charger_enable = charging;
        r.charge_level   = LEVEL_W'(held_level);
        return r;
    endfunction

    function automatic plan_row_t word_row(input logic [OP_W-1:0] op, input logic [9:0] smp,
                                           input bit typed, input logic en,
                                           input int unsigned lvl, input logic done);
        plan_row_t r;
        r = '{kind: ROW_WORD, default: '0};
        r.kind                = ROW_WORD;
        r.op                  = op;
        r.smp                 = smp;
        r.typed               = typed;
        r.want.charger_enable = en;
        r.want.charge_level   = LEVEL_W'(lvl);
        r.want.block_done     = done;
        return r;
    endfunction

    function automatic plan_row_t setup_row(input logic [CFG_DATA_W-1:0] low, high, min_on, len);
        plan_row_t r;
        r = '{kind: ROW_SETUP, default: '0};
        r.kind   = ROW_SETUP;
        r.low    = low;
        r.high   = high;
        r.min_on = min_on;
        r.len    = len;
        return r;
    endfunction

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (status_q.size() != 0);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] low, high, min_on, len);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_THRESHOLD;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= CFG_HIGH_THRESHOLD;
        cfg_data  <= high;
        @(posedge clk);
        cfg_index <= CFG_MIN_CHARGE;
        cfg_data  <= min_on;
        @(posedge clk);
        cfg_index <= CFG_BLOCK_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lvl_low   = 32'(low[LEVEL_W-1:0]);
        lvl_high  = 32'(high[LEVEL_W-1:0]);
        min_ticks = 32'(min_on[ON_W-1:0]);
        blk_len   = 32'(len[LEN_W-1:0]);
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [9:0] smp,
                             input bit typed, input bchc_result_t want);
        bchc_result_t predicted;
        while (idle_on && $urandom_range(0, 99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, smp};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = next_status(op, smp);
        status_q.push_back(typed ? want : predicted);
    endtask

    // Output side: checks each word and applies random and long back-pressure.
    always @(posedge clk)
    begin
        bchc_result_t got;
        bchc_result_t exp_word;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RESULT_W-1:0];
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_word = status_q.pop_front();
                    if (got.charger_enable !== exp_word.charger_enable)
                    begin
                        $display("%0t: charger_enable expected %0d, actual %0d", $time,
                                 exp_word.charger_enable, got.charger_enable);
                        errors++;
                    end
                    if (got.charge_level !== exp_word.charge_level)
                    begin
                        $display("%0t: charge_level expected %0d, actual %0d", $time,
                                 exp_word.charge_level, got.charge_level);
                        errors++;
                    end
                    if (got.block_done !== exp_word.block_done)
                    begin
                        $display("%0t: block_done expected %0d, actual %0d", $time,
                                 exp_word.block_done, got.block_done);
                        errors++;
                    end
                end
            end
            if (stall_toggle != stall_seen)
            begin
                stall_seen = stall_toggle;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 14);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("battery_charge_hysteresis_control_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t             plan[$];
        logic [OP_W-1:0]       op;
        logic [9:0]            smp;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] mt;
        logic [CFG_DATA_W-1:0] ln;
        int unsigned           eff;
        int unsigned           pick;

        // The held level starts at zero, so the first check turns the charger on.
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b1, 1'b1, 0, 1'b0));
        plan.push_back(word_row(OP_TICK,   10'd0,    1'b1, 1'b1, 0, 1'b0));
        plan.push_back(word_row(OP_UNUSED, 10'd1023, 1'b1, 1'b1, 0, 1'b0));
        plan.push_back(word_row(OP_SAMPLE, 10'd1023, 1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_SAMPLE, 10'd0,    1'b0, 1'b0, 0, 1'b0));
        // A zero length acts as one; the partial block closes on the next sample.
        plan.push_back(setup_row(24'd0, 24'd0, 24'd0, 24'd0));
        plan.push_back(word_row(OP_SAMPLE, 10'd0,    1'b1, 1'b1, 1023, 1'b1));
        plan.push_back(word_row(OP_SAMPLE, 10'd1023, 1'b1, 1'b1, 1023, 1'b1));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_TICK,   10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(setup_row(CFG_DATA_W'(SUM_MAX), CFG_DATA_W'(SUM_MAX), ON_MAX, 24'd255));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_TICK,   10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_TICK,   10'd0,    1'b0, 1'b0, 0, 1'b0));
        // The repeated low check must not have cleared the on-time.
        plan.push_back(setup_row(24'd0, 24'd0, 24'd1, 24'd2));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_SAMPLE, 10'd1023, 1'b0, 1'b0, 0, 1'b0));
        plan.push_back(word_row(OP_SAMPLE, 10'd512,  1'b0, 1'b0, 0, 1'b0));
        plan.push_back(setup_row(24'd1000, 24'd2000, 24'd0, 24'd128));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(setup_row(CFG_DATA_W'(SUM_MAX), 24'd0, ON_MAX, 24'd1));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));
        plan.push_back(setup_row(24'd0, 24'd0, ON_MAX, 24'd1));
        plan.push_back(word_row(OP_CHECK,  10'd0,    1'b0, 1'b0, 0, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETUP)
            begin
                write_config(plan[i].low, plan[i].high, plan[i].min_on, plan[i].len);
            end
            else
            begin
                send_word(plan[i].op, plan[i].smp, plan[i].typed, plan[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                ln = '0;
            end
            else if (pick == 1)
            begin
                ln = CFG_DATA_W'(MAX_BLOCK);
            end
            else if (pick == 2)
            begin
                ln = CFG_DATA_W'($urandom_range(MAX_BLOCK + 1, 255));
            end
            else
            begin
                ln = CFG_DATA_W'($urandom_range(1, 6));
            end
            eff = (32'(ln) == 0) ? 1 : ((32'(ln) > MAX_BLOCK) ? MAX_BLOCK : 32'(ln));
            lo = CFG_DATA_W'($urandom_range(0, eff * 1023));
            hi = CFG_DATA_W'(32'(lo) + $urandom_range(0, eff * 256));
            if (hi > CFG_DATA_W'(SUM_MAX))
            begin
                hi = CFG_DATA_W'(SUM_MAX);
            end
            pick = $urandom_range(0, 7);
            if (pick == 0)
            begin
                lo = CFG_DATA_W'(SUM_MAX);
            end
            else if (pick == 1)
            begin
                hi = '0;
            end
            else if (pick == 2)
            begin
                lo = '0;
                hi = CFG_DATA_W'(SUM_MAX);
            end
            mt = ($urandom_range(0, 4) == 0) ? ON_MAX : CFG_DATA_W'($urandom_range(0, 12));
            write_config(lo, hi, mt, ln);
            idle_on = (phase != 2);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == 4 && n == 30)
                begin
                    stall_toggle <= ~stall_toggle;
                end
                if (phase == 5 && n == 50)
                begin
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    op = OP_SAMPLE;
                end
                else if (pick < 80)
                begin
                    op = OP_TICK;
                end
                else if (pick < 95)
                begin
                    op = OP_CHECK;
                end
                else
                begin
                    op = OP_UNUSED;
                end
                pick = $urandom_range(0, 9);
                smp = (pick == 0) ? 10'd0 : ((pick == 1) ? 10'd1023 : 10'($urandom));
                send_word(op, smp, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("battery_charge_hysteresis_control_top test passed");
        end
        else
        begin
            $display("battery_charge_hysteresis_control_top test failed");
        end
        $finish;
    end

endmodule

/* battery_charge_hysteresis_control_top.f */
rtl/core/bchc_pkg.sv
rtl/core/bchc_step.sv
rtl/core/battery_charge_hysteresis_control_top.sv
rtl/core/bchc_checker.sv
verif/tb_top.sv
